// File: sv/ecc_pkg.sv
`default_nettype none
package ecc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_UP    = 3'd1,
    MODE_DOWN  = 3'd2,
    MODE_DOORS = 3'd3,
    MODE_EMERG = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DISP,
    ST_DONE
  } state_e;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DUTY_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STOP     = 2'd3;

  localparam logic [PERIOD_W-1:0] TRAVEL_PERIOD_RST = 16'd20;
  localparam logic [PERIOD_W-1:0] DOOR_PERIOD_RST   = 16'd30;
  localparam logic [DUTY_W-1:0]   DUTY_FULL_RST     = 7'd100;
  localparam logic [DUTY_W-1:0]   DUTY_STOP_RST     = 7'd0;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic scan_step;
    logic dispatch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } status_t;

  // A period of zero is loaded as one.
  function automatic logic [PERIOD_W-1:0] load_period(input logic [PERIOD_W-1:0] p);
    return (p == '0) ? PERIOD_W'(1) : p;
  endfunction

endpackage
`default_nettype wire

// File: sv/ecc_ctrl.sv
`default_nettype none
module ecc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire ecc_pkg::status_t status_i,
  output ecc_pkg::cmd_t        cmd_o
);
  import ecc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = status_i.need_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_in  = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_DISP: begin
        cmd_o.dispatch = 1'b1;
      end
      ST_DONE: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // The result register frees up as soon as its word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted word did not start execution");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result word dropped before it was taken");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && status_i.scan_last) |=> (state_q == ST_DISP))
    else $error("request scan did not end in dispatch");

endmodule
`default_nettype wire

// File: sv/ecc_dpath.sv
`default_nettype none
module ecc_dpath #(
  parameter int unsigned NUM_FLOORS = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ecc_pkg::cmd_t                cmd_i,
  output ecc_pkg::status_t                  status_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ecc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                         op_i,
  input  wire logic [3:0]                   floor_i,
  input  wire logic                         emergency_i,
  output logic [2:0]                        mode_o,
  output logic [1:0]                        direction_o,
  output logic [2:0]                        current_floor_o,
  output logic [2:0]                        target_floor_o,
  output logic [6:0]                        motor_duty_o,
  output logic [7:0]                        pending_mask_o
);
  import ecc_pkg::*;

  localparam int unsigned FW = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
  localparam logic [FW-1:0] LAST_FLOOR = FW'(NUM_FLOORS - 1);

  // Configuration registers.
  logic [PERIOD_W-1:0] travel_period_q, door_period_q;
  logic [DUTY_W-1:0]   duty_full_q, duty_stop_q;

  // Captured input word.
  logic       op_q, op_d;
  logic [3:0] floor_q, floor_d;
  logic       em_q, em_d;

  // Car state.
  mode_e               mode_q, mode_d;
  dir_e                dir_q, dir_d;
  logic [FW-1:0]       car_q, car_d;
  logic [FW-1:0]       goal_q, goal_d;
  logic [NUM_FLOORS-1:0] req_q, req_d;
  logic [PERIOD_W-1:0] travel_q, travel_d;
  logic [PERIOD_W-1:0] door_q, door_d;
  logic [DUTY_W-1:0]   duty_q, duty_d;

  // Nearest-request scan.
  logic [FW-1:0] idx_q, idx_d;
  logic [FW-1:0] best_q, best_d;
  logic [FW-1:0] best_dist_q, best_dist_d;
  logic          found_q, found_d;
  logic [FW-1:0] idx_dist;

  // Result registers.
  logic [2:0] mode_out_q, current_out_q, target_out_q;
  logic [1:0] dir_out_q;
  logic [6:0] duty_out_q;
  logic [7:0] pend_out_q;

  logic [FW-1:0]         car_step;
  logic                  req_in_range;
  logic [FW+2:0]         car_ext, goal_ext;
  logic [NUM_FLOORS+7:0] req_ext;

  assign req_in_range = ({1'b0, floor_q} < 5'(NUM_FLOORS));
  assign car_step = (mode_q == MODE_UP) ? (car_q + FW'(1)) :
                    ((car_q != '0) ? (car_q - FW'(1)) : car_q);
  assign idx_dist = (car_q > idx_q) ? (car_q - idx_q) : (idx_q - car_q);

  assign status_o.need_scan = (op_q == OP_TICK) && !em_q && (req_q != '0) &&
                              ((mode_q == MODE_IDLE) ||
                               (mode_q == MODE_DOORS && door_q == PERIOD_W'(1)));
  assign status_o.scan_last = (idx_q == LAST_FLOOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travel_period_q <= TRAVEL_PERIOD_RST;
      door_period_q   <= DOOR_PERIOD_RST;
      duty_full_q     <= DUTY_FULL_RST;
      duty_stop_q     <= DUTY_STOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TRAVEL_PERIOD: travel_period_q <= cfg_wdata_i;
        CFG_DOOR_PERIOD:   door_period_q   <= cfg_wdata_i;
        CFG_DUTY_FULL:     duty_full_q     <= cfg_wdata_i[DUTY_W-1:0];
        CFG_DUTY_STOP:     duty_stop_q     <= cfg_wdata_i[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    op_d        = op_q;
    floor_d     = floor_q;
    em_d        = em_q;
    mode_d      = mode_q;
    dir_d       = dir_q;
    car_d       = car_q;
    goal_d      = goal_q;
    req_d       = req_q;
    travel_d    = travel_q;
    door_d      = door_q;
    duty_d      = duty_q;
    idx_d       = idx_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    found_d     = found_q;

    if (cmd_i.load_in) begin
      op_d    = op_i;
      floor_d = floor_i;
      em_d    = emergency_i;
    end

    if (cmd_i.exec) begin
      idx_d   = '0;
      found_d = 1'b0;
      if (op_q == OP_REQUEST) begin
        if (req_in_range) begin
          req_d[floor_q[FW-1:0]] = 1'b1;
        end
      end else if (em_q) begin
        mode_d = MODE_EMERG;
        dir_d  = DIR_NONE;
        duty_d = duty_stop_q;
      end else begin
        case (mode_q)
          MODE_UP, MODE_DOWN: begin
            if (travel_q != '0) begin
              travel_d = travel_q - PERIOD_W'(1);
              if (travel_q == PERIOD_W'(1)) begin
                car_d = car_step;
                if (car_step == goal_q) begin
                  req_d[car_step] = 1'b0;
                  mode_d = MODE_DOORS;
                  dir_d  = DIR_NONE;
                  duty_d = duty_stop_q;
                  door_d = load_period(door_period_q);
                end else begin
                  travel_d = load_period(travel_period_q);
                end
              end
            end
          end
          MODE_DOORS: begin
            if (door_q != '0) begin
              door_d = door_q - PERIOD_W'(1);
              // With requests pending, the scan and dispatch follow instead.
              if (door_q == PERIOD_W'(1) && req_q == '0) begin
                mode_d = MODE_IDLE;
                dir_d  = DIR_NONE;
              end
            end
          end
          MODE_EMERG: begin
            duty_d = duty_stop_q;
          end
          default: begin
          end
        endcase
      end
    end

    // Strict compare keeps the lowest floor on a tie.
    if (cmd_i.scan_step) begin
      if (req_q[idx_q] && (!found_q || idx_dist < best_dist_q)) begin
        best_d      = idx_q;
        best_dist_d = idx_dist;
        found_d     = 1'b1;
      end
      idx_d = idx_q + FW'(1);
    end

    if (cmd_i.dispatch) begin
      goal_d = best_q;
      if (best_q > car_q) begin
        mode_d   = MODE_UP;
        dir_d    = DIR_UP;
        duty_d   = duty_full_q;
        travel_d = load_period(travel_period_q);
      end else if (best_q < car_q) begin
        mode_d   = MODE_DOWN;
        dir_d    = DIR_DOWN;
        duty_d   = duty_full_q;
        travel_d = load_period(travel_period_q);
      end else begin
        req_d[car_q] = 1'b0;
        mode_d = MODE_DOORS;
        dir_d  = DIR_NONE;
        duty_d = duty_stop_q;
        door_d = load_period(door_period_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      dir_q       <= DIR_NONE;
      car_q       <= '0;
      goal_q      <= '0;
      req_q       <= '0;
      travel_q    <= '0;
      door_q      <= '0;
      duty_q      <= DUTY_STOP_RST;
      idx_q       <= '0;
      best_q      <= '0;
      best_dist_q <= '0;
      found_q     <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      dir_q       <= dir_d;
      car_q       <= car_d;
      goal_q      <= goal_d;
      req_q       <= req_d;
      travel_q    <= travel_d;
      door_q      <= door_d;
      duty_q      <= duty_d;
      idx_q       <= idx_d;
      best_q      <= best_d;
      best_dist_q <= best_dist_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    floor_q <= floor_d;
    em_q    <= em_d;
  end

  assign car_ext  = {3'b000, car_q};
  assign goal_ext = {3'b000, goal_q};
  assign req_ext  = {8'h00, req_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mode_out_q    <= mode_q;
      dir_out_q     <= dir_q;
      current_out_q <= car_ext[2:0];
      target_out_q  <= goal_ext[2:0];
      duty_out_q    <= duty_q;
      pend_out_q    <= req_ext[7:0];
    end
  end

  assign mode_o          = mode_out_q;
  assign direction_o     = dir_out_q;
  assign current_floor_o = current_out_q;
  assign target_floor_o  = target_out_q;
  assign motor_duty_o    = duty_out_q;
  assign pending_mask_o  = pend_out_q;

  a_emerg_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_EMERG) |=> (mode_q == MODE_EMERG))
    else $error("emergency mode left without reset");

  a_car_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, car_q} < (FW+1)'(NUM_FLOORS)) && ({1'b0, goal_q} < (FW+1)'(NUM_FLOORS)))
    else $error("car or goal floor outside the shaft");

  a_dir_follows_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == MODE_UP) == (dir_q == DIR_UP)) &&
    ((mode_q == MODE_DOWN) == (dir_q == DIR_DOWN)))
    else $error("direction does not match the travel mode");

endmodule
`default_nettype wire

// File: sv/elevator_car_controller.sv
`default_nettype none
// Controller for one elevator car. Each input word is either a tick or a floor
// request, and each yields exactly one result word with the car state after it.
// A request or an ordinary tick is executed and its result registered. A tick
// that picks a new target also runs a scan for the nearest pending floor, which
// looks at one floor per cycle, before dispatch. One word is processed at a time;
// the next word is accepted while the previous result still waits in the output
// register, and a result that is not taken holds the following word's result
// back. Configuration writes belong in idle periods only.
module elevator_car_controller #(
  parameter int unsigned NUM_FLOORS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ecc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           op_i,
  input  wire logic [3:0]                     floor_i,
  input  wire logic                           emergency_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [2:0]                          mode_o,
  output logic [1:0]                          direction_o,
  output logic [2:0]                          current_floor_o,
  output logic [2:0]                          target_floor_o,
  output logic [6:0]                          motor_duty_o,
  output logic [7:0]                          pending_mask_o
);
  import ecc_pkg::*;

  cmd_t    cmd;
  status_t status;

  ecc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ecc_dpath #(
    .NUM_FLOORS (NUM_FLOORS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op_i),
    .floor_i         (floor_i),
    .emergency_i     (emergency_i),
    .mode_o          (mode_o),
    .direction_o     (direction_o),
    .current_floor_o (current_floor_o),
    .target_floor_o  (target_floor_o),
    .motor_duty_o    (motor_duty_o),
    .pending_mask_o  (pending_mask_o)
  );

endmodule
`default_nettype wire
